### rtl/ctra_pkg.sv
package ctra_pkg;

    localparam int NORM_FRAC = 24;
    localparam int FAC_W     = NORM_FRAC + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;
    localparam int INT_W     = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_FLOOR       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MIN        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_INV_SPAN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTENUATION_COEFF = 2'd3;

    localparam logic signed [15:0] RST_CLAMP_FLOOR       = -16'sd1000;
    localparam logic signed [15:0] RST_WINDOW_MIN        = -16'sd1024;
    localparam logic [23:0]        RST_WINDOW_INV_SPAN   = 24'd4846;
    localparam logic [15:0]        RST_ATTENUATION_COEFF = 16'd1638;

    localparam logic [FAC_W-1:0] FAC_ONE = {1'b1, {NORM_FRAC{1'b0}}};

    typedef struct packed {
        logic signed [15:0] clamp_floor;
        logic signed [15:0] window_min;
        logic [23:0]        window_inv_span;
        logic [15:0]        attenuation_coeff;
    } t_cfg;

    typedef struct packed {
        logic [FAC_W-1:0] fac;
        logic             last;
    } t_fac_item;

endpackage

### rtl/ct_ray_attenuation_accumulator_unit.sv
// ct ray attenuation accumulator: one ray sample per transfer (two voxel values and a
// fraction), interpolated, floor clamped, windowed, squared and folded into a running
// transmittance; a sample flagged last yields floor((1 - T) * 256) and restarts T at 1.0.
// sustains one sample per clock when nothing stalls, bounded by the single loop-carried
// transmittance multiply in the back end; a result passes the front pipeline and the
// factor queue before the back end queues it. a five-stage front pipeline computes the
// per-sample factor and feeds a QUEUE_DEPTH entry queue; a two-entry result queue
// decouples the output. write configuration only while the block is idle.
module ct_ray_attenuation_accumulator_unit #(
    parameter int TRANSMIT_FRAC_BITS = 24,
    parameter int QUEUE_DEPTH        = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ctra_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ctra_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic signed [15:0]                 i_value_low,
    input  logic signed [15:0]                 i_value_high,
    input  logic [15:0]                        i_frac,
    input  logic                               i_last,
    output logic                               empty,
    input  logic                               pop,
    output logic [ctra_pkg::INT_W-1:0]         o_intensity
);
    import ctra_pkg::*;

    t_cfg             r_cfg;
    logic             w_q_full, w_q_empty, w_q_push, w_q_pop;
    t_fac_item        w_q_in, w_q_out;
    logic             w_res_full, w_res_push;
    logic [INT_W-1:0] w_res_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clamp_floor       <= RST_CLAMP_FLOOR;
            r_cfg.window_min        <= RST_WINDOW_MIN;
            r_cfg.window_inv_span   <= RST_WINDOW_INV_SPAN;
            r_cfg.attenuation_coeff <= RST_ATTENUATION_COEFF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CLAMP_FLOOR:       r_cfg.clamp_floor       <= i_cfg_data[15:0];
                CFG_WINDOW_MIN:        r_cfg.window_min        <= i_cfg_data[15:0];
                CFG_WINDOW_INV_SPAN:   r_cfg.window_inv_span   <= i_cfg_data[23:0];
                CFG_ATTENUATION_COEFF: r_cfg.attenuation_coeff <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign full = w_q_full;

    ctra_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (push && !full),
        .i_value_low  (i_value_low),
        .i_value_high (i_value_high),
        .i_frac       (i_frac),
        .i_last       (i_last),
        .i_q_full     (w_q_full),
        .o_q_push     (w_q_push),
        .o_q_data     (w_q_in)
    );

    ctra_fifo #(
        .WIDTH ($bits(t_fac_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fac_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty)
    );

    ctra_back #(
        .TRANSMIT_FRAC_BITS (TRANSMIT_FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_data   (w_q_out),
        .i_q_empty  (w_q_empty),
        .o_q_pop    (w_q_pop),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res_data (w_res_data)
    );

    ctra_fifo #(
        .WIDTH (INT_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_data),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (o_intensity),
        .o_empty (empty)
    );

endmodule

### rtl/ctra_fifo.sv
module ctra_fifo #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_cnt;
    logic [AW-1:0]    n_wr_ptr, n_rd_ptr;
    logic [CW-1:0]    n_cnt;
    logic             w_push_ok, w_pop_ok;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_push_ok) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop_ok) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push_ok && !w_pop_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_push_ok && w_pop_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/ctra_front.sv
module ctra_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ctra_pkg::t_cfg     i_cfg,
    input  logic               i_accept,
    input  logic signed [15:0] i_value_low,
    input  logic signed [15:0] i_value_high,
    input  logic [15:0]        i_frac,
    input  logic               i_last,
    input  logic               i_q_full,
    output logic               o_q_push,
    output ctra_pkg::t_fac_item o_q_data
);
    import ctra_pkg::*;

    logic              w_en;
    logic [4:0]        r_vld;
    logic [4:0]        r_last;

    logic signed [16:0] w_diff;
    logic signed [16:0] w_frac_s;
    logic signed [33:0] w_prod;
    logic signed [33:0] w_iv;
    logic signed [33:0] r_iv;

    logic signed [33:0] w_fl;
    logic signed [33:0] w_ivc;
    logic signed [33:0] w_d;
    logic signed [33:0] w_dabs;
    logic [31:0]        r_mag;

    logic [55:0]        w_nprod;
    logic [39:0]        r_n;

    logic [63:0]        w_nsq;
    logic [40:0]        w_sq;
    logic [40:0]        r_sq;

    logic [56:0]        w_att;
    logic [40:0]        r_att;

    assign w_en = !i_q_full;

    // interpolation
    assign w_diff   = {i_value_high[15], i_value_high} - {i_value_low[15], i_value_low};
    assign w_frac_s = {1'b0, i_frac};
    assign w_prod   = w_diff * w_frac_s;
    assign w_iv     = {{2{i_value_low[15]}}, i_value_low, 16'h0000} + w_prod;

    // floor clamp and window offset
    assign w_fl   = {{2{i_cfg.clamp_floor[15]}}, i_cfg.clamp_floor, 16'h0000};
    assign w_ivc  = (r_iv < w_fl) ? w_fl : r_iv;
    assign w_d    = w_ivc - {{2{i_cfg.window_min[15]}}, i_cfg.window_min, 16'h0000};
    assign w_dabs = w_d[33] ? -w_d : w_d;

    // normalize
    assign w_nprod = {24'h000000, r_mag} * {32'h00000000, i_cfg.window_inv_span};

    // square, saturating huge values
    assign w_nsq = {32'h00000000, r_n[31:0]} * {32'h00000000, r_n[31:0]};
    assign w_sq  = (|r_n[39:32]) ? {1'b1, 40'h0} : {1'b0, w_nsq[63:24]};

    // weight
    assign w_att = {41'h0, i_cfg.attenuation_coeff} * {16'h0000, r_sq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[3:0], i_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_last <= {r_last[3:0], i_last};
            r_iv   <= w_iv;
            r_mag  <= w_dabs[31:0];
            r_n    <= w_nprod[55:16];
            r_sq   <= w_sq;
            r_att  <= w_att[56:16];
        end
    end

    assign o_q_push      = r_vld[4] && w_en;
    assign o_q_data.last = r_last[4];
    assign o_q_data.fac  = (|r_att[40:NORM_FRAC]) ? '0 :
                           FAC_ONE - {1'b0, r_att[NORM_FRAC-1:0]};

endmodule

### rtl/ctra_back.sv
module ctra_back #(
    parameter int TRANSMIT_FRAC_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ctra_pkg::t_fac_item           i_q_data,
    input  logic                          i_q_empty,
    output logic                          o_q_pop,
    input  logic                          i_res_full,
    output logic                          o_res_push,
    output logic [ctra_pkg::INT_W-1:0]    o_res_data
);
    import ctra_pkg::*;

    localparam int TW = TRANSMIT_FRAC_BITS + 1;
    localparam logic [TW-1:0] T_ONE = {1'b1, {TRANSMIT_FRAC_BITS{1'b0}}};

    logic [TW-1:0]          r_t;
    logic [TW-1:0]          n_t;
    logic [TW+FAC_W-1:0]    w_prod;
    logic [TW-1:0]          w_t_new;
    logic [TW-1:0]          w_rem;

    assign o_q_pop = !i_q_empty && (!i_q_data.last || !i_res_full);

    assign w_prod  = {{FAC_W{1'b0}}, r_t} * {{TW{1'b0}}, i_q_data.fac};
    assign w_t_new = w_prod[NORM_FRAC+TW-1:NORM_FRAC];
    assign w_rem   = T_ONE - w_t_new;

    assign o_res_push = o_q_pop && i_q_data.last;
    assign o_res_data = w_rem[TRANSMIT_FRAC_BITS:TRANSMIT_FRAC_BITS-INT_W+1];

    always_comb begin
        n_t = r_t;
        if (o_q_pop) begin
            n_t = i_q_data.last ? T_ONE : w_t_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t <= T_ONE;
        end else begin
            r_t <= n_t;
        end
    end

endmodule

### rtl/ctra_checker.sv
module ctra_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [8:0] o_intensity
);

    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_not_full_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input side full after reset");

    a_intensity_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_intensity <= 9'd256))
        else $error("intensity above 256");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_intensity)))
        else $error("waiting result changed or vanished");

endmodule

bind ct_ray_attenuation_accumulator_unit ctra_checker u_ctra_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_intensity (o_intensity)
);
